// ===== rtl/extent_cluster_packer_defines.svh =====
// ----------------------------------------------------------------------------
// extent_cluster_packer assertion macros
// Concurrent assertion helpers for the extent cluster packer, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef EXTENT_CLUSTER_PACKER_DEFINES_SVH
`define EXTENT_CLUSTER_PACKER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define ECP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("extent_cluster_packer: assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define ECP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("extent_cluster_packer: assertion failed");
`else
`define ECP_ASSERT_IMPLY(label, ante, cons)
`define ECP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/ecp_pkg.sv =====
// ----------------------------------------------------------------------------
// ecp_pkg
// Shared types, constants and helpers of the extent cluster packer.
// ----------------------------------------------------------------------------
package ecp_pkg;

  // field widths
  localparam int unsigned LEN_W      = 25;
  localparam int unsigned POS_W      = 24;
  localparam int unsigned GRP_W      = 16;
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned CS_W       = 5;
  localparam int unsigned AS_W       = 4;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned NUM_PARTS  = 3;

  // plan queue depth between front and back
  localparam int unsigned ECP_QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_CLUSTER_SHIFT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ALIGN_SHIFT   = 1'b1;

  // register reset values and cluster shift bounds
  localparam logic [CS_W-1:0] CS_RESET = 5'd20;
  localparam logic [AS_W-1:0] AS_RESET = 4'd12;
  localparam logic [CS_W-1:0] CS_MIN   = 5'd9;
  localparam logic [CS_W-1:0] CS_MAX   = 5'd24;

  localparam logic [GRP_W-1:0] GRP_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_PLACED = 2'd0,
    KIND_MEMORY = 2'd1,
    KIND_REJECT = 2'd2
  } part_kind_t;

  typedef struct packed {
    logic              start_batch;
    logic [LEN_W-1:0]  data_length;
    logic [ADDR_W-1:0] file_position;
    logic [ADDR_W-1:0] old_disk_position;
    logic [ADDR_W-1:0] owner_id;
  } ecp_in_t;

  typedef struct packed {
    part_kind_t        part_kind;
    logic [GRP_W-1:0]  group_index;
    logic [POS_W-1:0]  cluster_position;
    logic [LEN_W-1:0]  part_length;
    logic [ADDR_W-1:0] part_file_position;
    logic [ADDR_W-1:0] part_old_disk_position;
    logic [ADDR_W-1:0] part_owner;
    logic              last_part;
  } ecp_out_t;

  // one part of an extent, offset is relative to the extent start
  typedef struct packed {
    part_kind_t       kind;
    logic [GRP_W-1:0] grp;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] off;
  } ecp_part_t;

  // classified extent: head, aligned and tail slots with a present mask
  typedef struct packed {
    ecp_part_t [NUM_PARTS-1:0] parts;
    logic [NUM_PARTS-1:0]      present;
    logic [ADDR_W-1:0]         file_position;
    logic [ADDR_W-1:0]         old_disk_position;
    logic [ADDR_W-1:0]         owner_id;
  } ecp_plan_t;

  // effective cluster shift
  function automatic logic [CS_W-1:0] ecp_clamp_cs(input logic [CS_W-1:0] cs);
    logic [CS_W-1:0] res;
    if (cs < CS_MIN) res = CS_MIN;
    else if (cs > CS_MAX) res = CS_MAX;
    else res = cs;
    return res;
  endfunction

  // cluster size in bytes for an effective shift
  function automatic logic [LEN_W-1:0] ecp_cluster_size(input logic [CS_W-1:0] cs_eff);
    return LEN_W'(1) << cs_eff;
  endfunction

  // group count after taking a group, saturating
  function automatic logic [GRP_W-1:0] ecp_take(input logic open, input logic [GRP_W-1:0] g);
    logic [GRP_W-1:0] res;
    if (open && (g != GRP_MAX)) res = g + 1'b1;
    else res = g;
    return res;
  endfunction

  // group index from a group count
  function automatic logic [GRP_W-1:0] ecp_index(input logic [GRP_W-1:0] g);
    return (g == '0) ? '0 : g - 1'b1;
  endfunction

endpackage

// ===== rtl/ecp_front.sv =====
// ----------------------------------------------------------------------------
// ecp_front
// Holds configuration and packing state, accepts extents and splits each
// into a plan of up to three parts.
// ----------------------------------------------------------------------------
module ecp_front import ecp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ecp_in_t               in_data,
  input  logic                  q_full,
  output logic                  q_push,
  output ecp_plan_t             q_plan,
  output logic [LEN_W-1:0]      csize
);

  logic [CS_W-1:0]  cs_r, cs_nxt;
  logic [AS_W-1:0]  as_r, as_nxt;
  logic [POS_W-1:0] fill_r, fill_nxt;
  logic [GRP_W-1:0] grp_r, grp_nxt;
  logic             open_r, open_nxt;

  logic [CS_W-1:0]  cs_eff, as_eff;
  logic [LEN_W-1:0] amask, len;
  logic [LEN_W-1:0] fill0, fill1, fill2, fill3;
  logic [GRP_W-1:0] grp0, grp_h, grp_a_in, grp_a;
  logic             open0, open1, open_a_in;
  logic             reject, close, split, al_v, tail_v, wrap, accept;
  logic [LEN_W:0]   sum, over;
  logic [LEN_W-1:0] head_len, rem1, off1, al, tail, off2;

  // effective geometry
  always_comb begin
    cs_eff = ecp_clamp_cs(cs_r);
    as_eff = ({1'b0, as_r} > cs_eff) ? cs_eff : {1'b0, as_r};
    csize  = ecp_cluster_size(cs_eff);
    amask  = (LEN_W'(1) << as_eff) - LEN_W'(1);
  end

  // classify the extent
  always_comb begin
    len   = in_data.data_length;
    fill0 = in_data.start_batch ? '0 : {1'b0, fill_r};
    grp0  = in_data.start_batch ? '0 : grp_r;
    open0 = in_data.start_batch | open_r;

    reject = len > csize;
    close  = fill0 >= csize;
    fill1  = close ? '0 : fill0;
    open1  = close | open0;

    // head part fills the current cluster
    sum      = {1'b0, fill1} + {1'b0, len};
    split    = sum > {1'b0, csize};
    over     = sum - {1'b0, csize};
    head_len = csize - fill1;
    grp_h    = ecp_take(open1, grp0);

    rem1      = split ? over[LEN_W-1:0] : len;
    off1      = split ? head_len : '0;
    fill2     = split ? '0 : fill1;
    grp_a_in  = split ? grp_h : grp0;
    open_a_in = split | open1;

    // aligned part and memory tail
    al     = rem1 & ~amask;
    al_v   = al != '0;
    grp_a  = ecp_take(open_a_in, grp_a_in);
    fill3  = fill2 + al;
    wrap   = fill3 >= csize;
    tail   = rem1 & amask;
    tail_v = tail != '0;
    off2   = off1 + al;
  end

  // plan for the back end
  always_comb begin
    q_plan.file_position     = in_data.file_position;
    q_plan.old_disk_position = in_data.old_disk_position;
    q_plan.owner_id          = in_data.owner_id;
    if (reject) begin
      q_plan.parts[0] = '{kind: KIND_REJECT, grp: '0, pos: '0, len: len, off: '0};
    end else begin
      q_plan.parts[0] = '{kind: KIND_PLACED, grp: ecp_index(grp_h), pos: fill1[POS_W-1:0],
                          len: head_len, off: '0};
    end
    q_plan.parts[1] = '{kind: KIND_PLACED, grp: ecp_index(grp_a), pos: fill2[POS_W-1:0],
                        len: al, off: off1};
    q_plan.parts[2] = '{kind: KIND_MEMORY, grp: '0, pos: '0, len: tail, off: off2};
    q_plan.present  = {~reject & tail_v, ~reject & al_v, reject | split};
  end

  // handshake
  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;
  assign q_push   = accept & (q_plan.present != '0);

  // configuration and packing state update
  always_comb begin
    cs_nxt   = cs_r;
    as_nxt   = as_r;
    fill_nxt = fill_r;
    grp_nxt  = grp_r;
    open_nxt = open_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_CLUSTER_SHIFT: cs_nxt = cfg_wdata;
        CFG_ALIGN_SHIFT:   as_nxt = cfg_wdata[AS_W-1:0];
        default: ;
      endcase
    end
    if (accept) begin
      if (reject) begin
        fill_nxt = fill0[POS_W-1:0];
        grp_nxt  = grp0;
        open_nxt = open0;
      end else if (al_v) begin
        fill_nxt = wrap ? '0 : fill3[POS_W-1:0];
        grp_nxt  = grp_a;
        open_nxt = wrap;
      end else begin
        fill_nxt = fill2[POS_W-1:0];
        grp_nxt  = split ? grp_h : grp0;
        open_nxt = open_a_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r   <= CS_RESET;
      as_r   <= AS_RESET;
      fill_r <= '0;
      grp_r  <= '0;
      open_r <= 1'b1;
    end else begin
      cs_r   <= cs_nxt;
      as_r   <= as_nxt;
      fill_r <= fill_nxt;
      grp_r  <= grp_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

// ===== rtl/ecp_queue.sv =====
// ----------------------------------------------------------------------------
// ecp_queue
// Small first-in first-out queue of extent plans between front and back.
// ----------------------------------------------------------------------------
module ecp_queue import ecp_pkg::*; #(
  parameter int unsigned Depth = ECP_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ecp_plan_t plan_in,
  output logic      full,
  output logic      valid,
  output ecp_plan_t plan_out,
  input  logic      pop
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ecp_plan_t         mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;

  assign full     = count_r == CntW'(Depth);
  assign valid    = count_r != '0;
  assign plan_out = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // plan storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= plan_in;
  end

endmodule

// ===== rtl/ecp_back.sv =====
// ----------------------------------------------------------------------------
// ecp_back
// Walks the parts of the queued plan, one per cycle while out_ready allows,
// and drives the result register with part positions and the last-part flag.
// ----------------------------------------------------------------------------
module ecp_back import ecp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  ecp_plan_t q_plan,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output ecp_out_t  out_data
);

  logic [NUM_PARTS-1:0] done_r, done_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ecp_out_t             out_data_r;

  logic [NUM_PARTS-1:0] rest, cur;
  logic                 last, load;
  ecp_part_t            desc;

  // pick the next part still to send
  always_comb begin
    rest = q_plan.present & ~done_r;
    cur  = rest & (~rest + 1'b1);
    last = (rest & ~cur) == '0;
    if (cur[0]) desc = q_plan.parts[0];
    else if (cur[1]) desc = q_plan.parts[1];
    else desc = q_plan.parts[2];
  end

  assign load  = q_valid & (~out_valid_r | out_ready);
  assign q_pop = load & last;

  // part progress and result valid
  always_comb begin
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      done_nxt      = last ? '0 : (done_r | cur);
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.part_kind              <= desc.kind;
      out_data_r.group_index            <= desc.grp;
      out_data_r.cluster_position       <= desc.pos;
      out_data_r.part_length            <= desc.len;
      out_data_r.part_file_position     <= q_plan.file_position + ADDR_W'(desc.off);
      out_data_r.part_old_disk_position <= q_plan.old_disk_position + ADDR_W'(desc.off);
      out_data_r.part_owner             <= q_plan.owner_id;
      out_data_r.last_part              <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/extent_cluster_packer.sv =====
// ----------------------------------------------------------------------------
// extent_cluster_packer
// Packs data extents into fixed-size clusters, splitting overflowing extents
// into a cluster head, an aligned part and an unaligned memory tail.
// ----------------------------------------------------------------------------
// The front stage takes one extent per cycle while the plan queue has room,
// updates the fill offset and group count at once and queues the extent's
// parts; the back stage sends one result per cycle from its output register
// while out_ready allows, one per part of an extent and none for an empty
// extent. The first result of an extent passes through the plan queue and
// the back-stage result register. Configuration writes take effect on the
// next cycle and must only be made while the block is idle.
module extent_cluster_packer import ecp_pkg::*; #(
  parameter int unsigned QueueDepth = ECP_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ecp_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ecp_out_t              out_data
);

`include "extent_cluster_packer_defines.svh"

  logic             q_push, q_full, q_valid, q_pop;
  ecp_plan_t        q_plan_in, q_plan_out;
  logic [LEN_W-1:0] csize;

  // extent classification and packing state
  ecp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_plan    (q_plan_in),
    .csize     (csize)
  );

  // plan queue
  ecp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .plan_in  (q_plan_in),
    .full     (q_full),
    .valid    (q_valid),
    .plan_out (q_plan_out),
    .pop      (q_pop)
  );

  // part sequencing and result register
  ecp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_plan    (q_plan_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a placed part never runs past the end of its cluster
  `ECP_ASSERT_IMPLY(a_placed_fits, out_valid && out_data.part_kind == KIND_PLACED, ((LEN_W + 1)'(out_data.cluster_position) + (LEN_W + 1)'(out_data.part_length) <= (LEN_W + 1)'(csize)))
  // a rejected extent gives a single result
  `ECP_ASSERT_IMPLY(a_reject_last, out_valid && out_data.part_kind == KIND_REJECT, out_data.last_part)
  // only extents with at least one part enter the queue
  `ECP_ASSERT_IMPLY(a_push_nonempty, q_push, q_plan_in.present != '0)
  // sending the last part of a full queue frees a slot
  `ECP_ASSERT_NEXT(a_pop_frees, q_pop && !q_push && q_full, !q_full)

endmodule
